### hdl/tsrs_pkg.sv
// Package for the timed shutter release sequencer.
// Field widths, register addresses, phase codes, and the config and result bundle types.
// No dependencies.
package tsrs_pkg;

  localparam int TIME_W    = 32;
  localparam int SHOT_W    = 7;
  localparam int DELAY_W   = 13;
  localparam int PHASE_W   = 3;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int OFF_SHT_W = DELAY_W + 1;
  localparam int OFF_REL_W = DELAY_W + 1;
  localparam int OFF_FIN_W = DELAY_W + 2;

  localparam logic [OFF_SHT_W-1:0] FOCUS_TO_SHUTTER_MS   = OFF_SHT_W'(10);
  localparam logic [OFF_REL_W-1:0] FOCUS_TO_RELEASE_MS   = OFF_REL_W'(50);

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_SHOT_COUNT = 2'd0;
  localparam logic [1:0] REG_DESHAKE    = 2'd1;
  localparam logic [1:0] REG_SAVE       = 2'd2;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_FOCUS   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SHUTTER = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FINISH  = 3'd4;

  // offsets from the planning tick to each deadline
  typedef struct packed {
    logic [SHOT_W-1:0]    shot_count;
    logic [DELAY_W-1:0]   off_focus;
    logic [OFF_SHT_W-1:0] off_shutter;
    logic [OFF_REL_W-1:0] off_release;
    logic [OFF_FIN_W-1:0] off_finish;
  } cfg_t;

  typedef struct packed {
    logic               focus_line;
    logic               shutter_line;
    logic [PHASE_W-1:0] phase;
  } res_t;

endpackage

### hdl/tsrs_cfg.sv
// Configuration registers of the shutter sequencer, APB-style access.
// Also holds the precomputed deadline offsets. Depends on tsrs_pkg.
module tsrs_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsrs_pkg::ADDR_W-1:0] paddr,
  input  logic [tsrs_pkg::DATA_W-1:0] pwdata,
  output logic [tsrs_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output tsrs_pkg::cfg_t              cfg
);
  import tsrs_pkg::*;

  logic [SHOT_W-1:0]  shot_count;
  logic [DELAY_W-1:0] deshake_delay_ms;
  logic [DELAY_W-1:0] save_duration_ms;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      shot_count       <= SHOT_W'(1);
      deshake_delay_ms <= DELAY_W'(1);
      save_duration_ms <= DELAY_W'(1);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SHOT_COUNT: shot_count       <= pwdata[SHOT_W-1:0];
        REG_DESHAKE:    deshake_delay_ms <= pwdata[DELAY_W-1:0];
        REG_SAVE:       save_duration_ms <= pwdata[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SHOT_COUNT: prdata = DATA_W'(shot_count);
      REG_DESHAKE:    prdata = DATA_W'(deshake_delay_ms);
      REG_SAVE:       prdata = DATA_W'(save_duration_ms);
      default:        prdata = '0;
    endcase
  end

  // offsets are registered from the config registers, so they settle in the cycle after a write
  always_ff @(posedge clk) begin
    cfg.shot_count  <= shot_count;
    cfg.off_focus   <= deshake_delay_ms;
    cfg.off_shutter <= OFF_SHT_W'(deshake_delay_ms) + FOCUS_TO_SHUTTER_MS;
    cfg.off_release <= OFF_REL_W'(deshake_delay_ms) + FOCUS_TO_RELEASE_MS;
    cfg.off_finish  <= OFF_FIN_W'(deshake_delay_ms) + OFF_FIN_W'(FOCUS_TO_RELEASE_MS)
                       + OFF_FIN_W'(save_duration_ms);
  end

endmodule

### hdl/tsrs_core.sv
// Phase sequencer: deadline planning, compare and line levels.
// Updates its state once per consumed transaction. Depends on tsrs_pkg.
module tsrs_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [tsrs_pkg::TIME_W-1:0] now_ms,
  input  logic                        click_request,
  input  tsrs_pkg::cfg_t              cfg,
  output tsrs_pkg::res_t              res
);
  import tsrs_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [SHOT_W-1:0]  shots_left;
  logic [SHOT_W-1:0]  shots_left_next;
  logic               focus_level;
  logic               focus_level_next;
  logic               shutter_level;
  logic               shutter_level_next;
  logic [TIME_W-1:0]  focus_deadline;
  logic [TIME_W-1:0]  shutter_deadline;
  logic [TIME_W-1:0]  release_deadline;
  logic [TIME_W-1:0]  finish_deadline;
  logic [TIME_W-1:0]  sel_deadline;
  logic               due;
  logic               plan;

  always_comb begin
    unique case (phase)
      PH_FOCUS:   sel_deadline = focus_deadline;
      PH_SHUTTER: sel_deadline = shutter_deadline;
      PH_RELEASE: sel_deadline = release_deadline;
      default:    sel_deadline = finish_deadline;
    endcase
  end

  assign due = now_ms > sel_deadline;

  always_comb begin
    phase_next         = phase;
    shots_left_next    = shots_left;
    focus_level_next   = focus_level;
    shutter_level_next = shutter_level;
    plan               = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (click_request) begin
          shots_left_next = cfg.shot_count;
          plan            = 1'b1;
          phase_next      = PH_FOCUS;
        end
      end
      PH_FOCUS: begin
        if (due) begin
          focus_level_next = 1'b0;
          phase_next       = PH_SHUTTER;
        end
      end
      PH_SHUTTER: begin
        if (due) begin
          shutter_level_next = 1'b0;
          phase_next         = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        if (due) begin
          focus_level_next   = 1'b1;
          shutter_level_next = 1'b1;
          phase_next         = PH_FINISH;
        end
      end
      PH_FINISH: begin
        if (due) begin
          if (shots_left > SHOT_W'(1)) begin
            shots_left_next = shots_left - SHOT_W'(1);
            plan            = 1'b1;
            phase_next      = PH_FOCUS;
          end else begin
            shots_left_next = '0;
            phase_next      = PH_IDLE;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      shots_left    <= '0;
      focus_level   <= 1'b1;
      shutter_level <= 1'b1;
    end else if (fire) begin
      phase         <= phase_next;
      shots_left    <= shots_left_next;
      focus_level   <= focus_level_next;
      shutter_level <= shutter_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      focus_deadline   <= '0;
      shutter_deadline <= '0;
      release_deadline <= '0;
      finish_deadline  <= '0;
    end else if (fire && plan) begin
      focus_deadline   <= now_ms + TIME_W'(cfg.off_focus);
      shutter_deadline <= now_ms + TIME_W'(cfg.off_shutter);
      release_deadline <= now_ms + TIME_W'(cfg.off_release);
      finish_deadline  <= now_ms + TIME_W'(cfg.off_finish);
    end
  end

  assign res.focus_line   = focus_level_next;
  assign res.shutter_line = shutter_level_next;
  assign res.phase        = phase_next;

  a_focus_pressed: assert property (@(posedge clk) disable iff (rst)
    !focus_level |-> (phase == PH_SHUTTER || phase == PH_RELEASE))
    else $error("focus pressed outside shutter/release phases");

  a_shutter_pressed: assert property (@(posedge clk) disable iff (rst)
    !shutter_level |-> (phase == PH_RELEASE))
    else $error("shutter pressed outside release phase");

  a_idle_no_shots: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (shots_left == '0))
    else $error("shots left while idle");

  a_hold_no_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(phase) && $stable(shots_left))
    else $error("state moved without a transaction");

endmodule

### hdl/timed_shutter_release_sequencer.sv
// Top level of the timed shutter release sequencer.
// Path from input transaction to result: input register, then result register.
// Throughput: one transaction per cycle unless out_stall holds the result register; the phase
// compare and deadline adds sit between the input and result registers.
// Reset: synchronous, active high; phase idle, lines released, registers at 1.
// Depends on tsrs_pkg, tsrs_cfg and tsrs_core.
module timed_shutter_release_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsrs_pkg::ADDR_W-1:0] paddr,
  input  logic [tsrs_pkg::DATA_W-1:0] pwdata,
  output logic [tsrs_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tsrs_pkg::TIME_W-1:0] now_ms,
  input  logic                        click_request,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        focus_line,
  output logic                        shutter_line,
  output logic                        ready_res,
  output logic [tsrs_pkg::PHASE_W-1:0] phase
);
  import tsrs_pkg::*;

  cfg_t              cfg;
  res_t              res;
  logic              s1_valid;
  logic [TIME_W-1:0] s1_now;
  logic              s1_req;
  logic              out_free;
  logic              adv;
  logic              in_take;

  assign out_free = !out_valid || !out_stall;
  assign adv      = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  tsrs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsrs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (adv),
    .now_ms        (s1_now),
    .click_request (s1_req),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now <= now_ms;
      s1_req <= click_request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      focus_line   <= res.focus_line;
      shutter_line <= res.shutter_line;
      ready_res    <= (res.phase == PH_IDLE);
      phase        <= res.phase;
    end
  end

endmodule

### dv/timed_shutter_release_sequencer_tb.sv
// Self-checking testbench for timed_shutter_release_sequencer: directed and random ticks,
// with a transaction-level predictor of the shot phases and the focus and shutter line levels.
// Depends on tsrs_pkg and the RTL under hdl/.
module timed_shutter_release_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsrs_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned RANDOM_ROUNDS = 12;
  localparam int unsigned TICKS_PER_ROUND = 30;

  typedef struct packed {
    logic               focus_line;
    logic               shutter_line;
    logic               ready_res;
    logic [PHASE_W-1:0] phase;
  } line_state_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [TIME_W-1:0]   now_ms = '0;
  logic                click_request = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b1;
  logic                focus_line;
  logic                shutter_line;
  logic                ready_res;
  logic [PHASE_W-1:0]  phase;

  // predictor state, reset values
  logic [SHOT_W-1:0]   cfg_shots = SHOT_W'(1);
  logic [DELAY_W-1:0]  cfg_deshake = DELAY_W'(1);
  logic [DELAY_W-1:0]  cfg_save = DELAY_W'(1);
  logic [PHASE_W-1:0]  seq_phase = PH_IDLE;
  logic [TIME_W-1:0]   at_focus = '0;
  logic [TIME_W-1:0]   at_shutter = '0;
  logic [TIME_W-1:0]   at_release = '0;
  logic [TIME_W-1:0]   at_finish = '0;
  logic [SHOT_W-1:0]   shots_remaining = '0;
  logic                focus_lvl = 1'b1;
  logic                shutter_lvl = 1'b1;

  line_state_t         expected_lines[$];
  logic [TIME_W-1:0]   last_ms = '0;
  int unsigned         mismatches = 0;
  bit                  tx_eager = 1'b0;
  bit                  rx_eager = 1'b0;
  int unsigned         rx_hold_cycles = 0;

  timed_shutter_release_sequencer i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .now_ms        (now_ms),
    .click_request (click_request),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .focus_line    (focus_line),
    .shutter_line  (shutter_line),
    .ready_res     (ready_res),
    .phase         (phase)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void plan_exposure(input logic [TIME_W-1:0] t);
    at_focus   = t + TIME_W'(cfg_deshake);
    at_shutter = at_focus + TIME_W'(FOCUS_TO_SHUTTER_MS);
    at_release = at_focus + TIME_W'(FOCUS_TO_RELEASE_MS);
    at_finish  = at_release + TIME_W'(cfg_save);
  endfunction

  function automatic line_state_t step_sequencer(input logic [TIME_W-1:0] t, input logic req);
    line_state_t r;
    case (seq_phase)
      PH_IDLE: begin
        if (req) begin
          shots_remaining = cfg_shots;
          plan_exposure(t);
          seq_phase = PH_FOCUS;
        end
      end
      PH_FOCUS: begin
        if (t > at_focus) begin
          focus_lvl = 1'b0;
          seq_phase = PH_SHUTTER;
        end
      end
      PH_SHUTTER: begin
        if (t > at_shutter) begin
          shutter_lvl = 1'b0;
          seq_phase = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        if (t > at_release) begin
          shutter_lvl = 1'b1;
          focus_lvl = 1'b1;
          seq_phase = PH_FINISH;
        end
      end
      PH_FINISH: begin
        if (t > at_finish) begin
          if (shots_remaining > SHOT_W'(1)) begin
            shots_remaining = shots_remaining - SHOT_W'(1);
            plan_exposure(t);
            seq_phase = PH_FOCUS;
          end else begin
            shots_remaining = '0;
            seq_phase = PH_IDLE;
          end
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
    r.focus_line   = focus_lvl;
    r.shutter_line = shutter_lvl;
    r.ready_res    = (seq_phase == PH_IDLE);
    r.phase        = seq_phase;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] current_deadline();
    case (seq_phase)
      PH_FOCUS:   return at_focus;
      PH_SHUTTER: return at_shutter;
      PH_RELEASE: return at_release;
      PH_FINISH:  return at_finish;
      default:    return last_ms;
    endcase
  endfunction

  task automatic send_tick(input logic [TIME_W-1:0] t, input logic req);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms <= t;
    click_request <= req;
    do @(posedge clk); while (in_stall);
    expected_lines.push_back(step_sequencer(t, req));
    last_ms = t;
  endtask

  // stop offering ticks and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SHOT_COUNT: cfg_shots = value[SHOT_W-1:0];
      REG_DESHAKE:    cfg_deshake = value[DELAY_W-1:0];
      REG_SAVE:       cfg_save = value[DELAY_W-1:0];
      default: ;
    endcase
    if (idx == REG_UNUSED) begin
      psel <= 1'b0;
      penable <= 1'b0;
    end else begin
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== value) begin
        $display("%0t: register %0d readback expected %0d actual %0d", $time, idx, value, got);
        mismatches++;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    line_state_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        $display("%0t: unexpected result expected none actual phase %0d focus %0b shutter %0b",
                 $time, phase, focus_line, shutter_line);
        mismatches++;
      end else begin
        want = expected_lines.pop_front();
        compare_field("focus_line", 32'(want.focus_line), 32'(focus_line));
        compare_field("shutter_line", 32'(want.shutter_line), 32'(shutter_line));
        compare_field("ready_res", 32'(want.ready_res), 32'(ready_res));
        compare_field("phase", 32'(want.phase), 32'(phase));
      end
    end
  end

  initial begin : result_receiver
    int unsigned wait_cycles;
    forever begin
      if (rx_hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      wait_cycles = rx_eager ? 0 : $urandom_range(0, 19);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // zero delays, strict deadline compare, request while busy
  task automatic test_single_shot_timing();
    settle();
    write_reg(REG_SHOT_COUNT, 32'd1);
    write_reg(REG_DESHAKE, 32'd0);
    write_reg(REG_SAVE, 32'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_tick(32'd0, 1'b0);
    send_tick(32'd100, 1'b1);
    send_tick(at_focus, 1'b1);
    send_tick(at_focus + 1, 1'b0);
    send_tick(at_shutter, 1'b0);
    send_tick(at_shutter + 1, 1'b1);
    send_tick(at_release + 1, 1'b0);
    send_tick(at_finish, 1'b0);
    send_tick(at_finish + 1, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b0);
  endtask

  // zero shot count behaves as one shot; deadlines wrap past the top of the timer
  task automatic test_zero_count_and_wrap();
    settle();
    write_reg(REG_SHOT_COUNT, 32'd0);
    write_reg(REG_DESHAKE, 32'd8191);
    write_reg(REG_SAVE, 32'd8191);
    send_tick(32'hFFFF_FFFF - 32'd5000, 1'b1);
    send_tick(32'hFFFF_FFFF, 1'b0);
    send_tick(32'd0, 1'b0);
    send_tick(at_shutter + 1, 1'b0);
    send_tick(at_release + 1, 1'b0);
    send_tick(at_finish, 1'b0);
    send_tick(at_finish + 1, 1'b0);
  endtask

  // long shot run with the receiver held off so the pipeline fills
  task automatic test_full_run_under_backpressure();
    settle();
    write_reg(REG_SHOT_COUNT, 32'd30);
    write_reg(REG_DESHAKE, 32'd8191);
    write_reg(REG_SAVE, 32'd8191);
    tx_eager = 1'b1;
    rx_hold_cycles = 300;
    send_tick(32'd5000, 1'b1);
    while (seq_phase != PH_IDLE)
      send_tick(current_deadline() + 1, 1'($urandom_range(0, 1)));
    tx_eager = 1'b0;
  endtask

  task automatic random_tick();
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] t;
    logic              req;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    req = 1'($urandom_range(0, 1));
    due = current_deadline();
    if (pick < 8) begin
      t = $urandom;
    end else if (seq_phase == PH_IDLE) begin
      req = (pick < 80);
      if (pick < 15)
        t = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 9000));
      else
        t = last_ms + TIME_W'($urandom_range(0, 2000));
    end else if (pick < 25) begin
      t = due;
    end else if (pick < 35) begin
      t = due - TIME_W'($urandom_range(1, 30));
    end else if (pick < 45) begin
      t = due + TIME_W'($urandom_range(1, 100000));
    end else begin
      t = due + TIME_W'($urandom_range(1, 5));
    end
    send_tick(t, req);
  endtask

  function automatic logic [DATA_W-1:0] random_delay();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return 32'd8191;
      2:       return $urandom_range(0, 30);
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  task automatic test_random_sequences();
    logic [DATA_W-1:0] shots;
    for (int unsigned round = 0; round < RANDOM_ROUNDS; round++) begin
      settle();
      case ($urandom_range(0, 7))
        0:       shots = 32'd0;
        1:       shots = 32'd127;
        default: shots = $urandom_range(1, 4);
      endcase
      write_reg(REG_SHOT_COUNT, shots);
      write_reg(REG_DESHAKE, random_delay());
      write_reg(REG_SAVE, random_delay());
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      repeat (TICKS_PER_ROUND) random_tick();
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_single_shot_timing();
    test_zero_count_and_wrap();
    test_full_run_under_backpressure();
    test_random_sequences();
    settle();
    repeat (24) @(posedge clk);
    if (mismatches == 0 && expected_lines.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
hdl/tsrs_pkg.sv
hdl/tsrs_cfg.sv
hdl/tsrs_core.sv
hdl/timed_shutter_release_sequencer.sv
dv/timed_shutter_release_sequencer_tb.sv
